### design/mhbf_pkg.sv
// ----------------------------------------------------------------------------
// mhbf_pkg: shared types and constants of the memory-hard block fill engine
// Holds the transaction types, the datapath command set and its status flags.
// ----------------------------------------------------------------------------
package mhbf_pkg;

  localparam int MEM_WORDS        = 65536;
  localparam int ADDR_W           = 16;
  localparam int MAX_LANES        = 8;
  localparam int MAX_DIGEST_WORDS = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic [2:0] REG_LANE_COUNT      = 3'd0;
  localparam logic [2:0] REG_BLOCKS_PER_HALF = 3'd1;
  localparam logic [2:0] REG_BLOCK_WORDS     = 3'd2;
  localparam logic [2:0] REG_PASS_COUNT      = 3'd3;
  localparam logic [2:0] REG_DIGEST_WORDS    = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  lane_index;
    logic [11:0] seed_word_index;
    logic [31:0] seed_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [3:0]  digest_index;
    logic        last_word;
    logic        status;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_MUL_LLEN,
    CMD_LD_MUL,
    CMD_LD_WR,
    CMD_CK_MUL,
    CMD_ERR_OUT,
    CMD_RUN_INIT,
    CMD_F_MASK,
    CMD_F_SRC,
    CMD_SQ1,
    CMD_SQ2,
    CMD_SQ3,
    CMD_S_SRC,
    CMD_ADDR_SRC,
    CMD_ADDR_DST,
    CMD_ADDR_SET,
    CMD_CH_RD,
    CMD_CH_MUL,
    CMD_CH_ADD,
    CMD_BLK_NEXT,
    CMD_LANE_NEXT,
    CMD_DG_RD,
    CMD_DG_ACC,
    CMD_DG_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic is_run;
    logic cfg_err;
    logic blk_end;
    logic half;
    logic lane_last;
    logic word_last;
    logic pass_last;
    logic k_last;
  } dp_stat_t;

endpackage

### design/memory_hard_block_fill_top.sv
// ----------------------------------------------------------------------------
// memory_hard_block_fill_top: memory-hard block fill engine
// Loads seed blocks into a 64K-word memory, fills every lane and emits the
// lane-XOR digest of the final words.
// ----------------------------------------------------------------------------
// The engine takes one transaction at a time: start is sampled only while
// busy is low. A load transaction writes one seed word when its indices fit
// the layout; it gives no result. A run transaction first checks the layout
// and, if a size is zero, there are too many lanes or the lanes do not fit
// the memory, delivers a single error result. Otherwise it fills each lane.
// Every block first sets up its source and destination addresses, then
// chains its words for every pass: each word goes through one memory
// read, one multiply and one add on a single shared multiplier, and every
// word depends on the one before. The digest then XORs one word per lane
// for each digest word. Results appear on out_data for exactly one cycle with
// out_strobe high; the receiver cannot stall them, so it must take every
// strobed transaction. Configuration writes are accepted at any cycle but
// must only be issued while busy is low and no run is in flight.
// ----------------------------------------------------------------------------
module memory_hard_block_fill_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mhbf_pkg::in_item_t   in_data,
  output logic                out_strobe,
  output mhbf_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // Command from the sequencer and status flags back from the datapath.
  mhbf_pkg::dp_cmd_t  cmd;
  mhbf_pkg::dp_stat_t stat;

  mhbf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mhbf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

### design/mhbf_ctrl.sv
// ----------------------------------------------------------------------------
// mhbf_ctrl: sequencer of the block fill engine
// Walks loads, the layout check, both fill halves and the digest readout.
// ----------------------------------------------------------------------------
module mhbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mhbf_pkg::dp_stat_t stat,
  output mhbf_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_L1, ST_L2, ST_L3, ST_CK1, ST_CK2, ST_CK3, ST_ERR,
    ST_TEST, ST_F_MASK, ST_F_SRC, ST_S1, ST_S2, ST_S3, ST_S_SRC,
    ST_A1, ST_A2, ST_A3, ST_C_RD, ST_C_MUL, ST_C_ADD, ST_BLK, ST_LANE,
    ST_D_RD, ST_D_ACC, ST_D_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = mhbf_pkg::CMD_NOP;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd       = mhbf_pkg::CMD_ACCEPT;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: state_nxt = stat.is_run ? ST_CK1 : ST_L1;
      ST_L1: begin cmd = mhbf_pkg::CMD_MUL_LLEN; state_nxt = ST_L2; end
      ST_L2: begin cmd = mhbf_pkg::CMD_LD_MUL;   state_nxt = ST_L3; end
      ST_L3: begin cmd = mhbf_pkg::CMD_LD_WR;    state_nxt = ST_IDLE; end
      ST_CK1: begin cmd = mhbf_pkg::CMD_MUL_LLEN; state_nxt = ST_CK2; end
      ST_CK2: begin cmd = mhbf_pkg::CMD_CK_MUL;   state_nxt = ST_CK3; end
      ST_CK3: begin
        if (stat.cfg_err) begin
          state_nxt = ST_ERR;
        end else begin
          cmd       = mhbf_pkg::CMD_RUN_INIT;
          state_nxt = ST_TEST;
        end
      end
      ST_ERR: begin cmd = mhbf_pkg::CMD_ERR_OUT; state_nxt = ST_IDLE; end
      ST_TEST: begin
        if (stat.blk_end) state_nxt = ST_LANE;
        else if (stat.half) state_nxt = ST_S1;
        else state_nxt = ST_F_MASK;
      end
      ST_F_MASK: begin cmd = mhbf_pkg::CMD_F_MASK; state_nxt = ST_F_SRC; end
      ST_F_SRC:  begin cmd = mhbf_pkg::CMD_F_SRC;  state_nxt = ST_A1; end
      ST_S1:     begin cmd = mhbf_pkg::CMD_SQ1;    state_nxt = ST_S2; end
      ST_S2:     begin cmd = mhbf_pkg::CMD_SQ2;    state_nxt = ST_S3; end
      ST_S3:     begin cmd = mhbf_pkg::CMD_SQ3;    state_nxt = ST_S_SRC; end
      ST_S_SRC:  begin cmd = mhbf_pkg::CMD_S_SRC;  state_nxt = ST_A1; end
      ST_A1:     begin cmd = mhbf_pkg::CMD_ADDR_SRC; state_nxt = ST_A2; end
      ST_A2:     begin cmd = mhbf_pkg::CMD_ADDR_DST; state_nxt = ST_A3; end
      ST_A3:     begin cmd = mhbf_pkg::CMD_ADDR_SET; state_nxt = ST_C_RD; end
      ST_C_RD:   begin cmd = mhbf_pkg::CMD_CH_RD;  state_nxt = ST_C_MUL; end
      ST_C_MUL:  begin cmd = mhbf_pkg::CMD_CH_MUL; state_nxt = ST_C_ADD; end
      ST_C_ADD: begin
        cmd       = mhbf_pkg::CMD_CH_ADD;
        state_nxt = (stat.word_last && stat.pass_last) ? ST_BLK : ST_C_RD;
      end
      ST_BLK: begin cmd = mhbf_pkg::CMD_BLK_NEXT; state_nxt = ST_TEST; end
      ST_LANE: begin
        cmd       = mhbf_pkg::CMD_LANE_NEXT;
        state_nxt = (stat.lane_last && stat.half) ? ST_D_RD : ST_TEST;
      end
      ST_D_RD: begin cmd = mhbf_pkg::CMD_DG_RD; state_nxt = ST_D_ACC; end
      ST_D_ACC: begin
        cmd       = mhbf_pkg::CMD_DG_ACC;
        state_nxt = stat.lane_last ? ST_D_OUT : ST_D_RD;
      end
      ST_D_OUT: begin
        cmd       = mhbf_pkg::CMD_DG_OUT;
        state_nxt = stat.k_last ? ST_IDLE : ST_D_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### design/mhbf_dpath.sv
// ----------------------------------------------------------------------------
// mhbf_dpath: datapath of the block fill engine
// Word memory, configuration registers, the shared multiplier and counters.
// ----------------------------------------------------------------------------
module mhbf_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  mhbf_pkg::dp_cmd_t    cmd,
  output mhbf_pkg::dp_stat_t   stat,
  input  mhbf_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_strobe,
  output mhbf_pkg::out_item_t  out_data
);

  localparam int AW = mhbf_pkg::ADDR_W;

  function automatic logic [14:0] rev15(input logic [14:0] x);
    logic [14:0] r;
    for (int b = 0; b < 15; b++) r[b] = x[14-b];
    return r;
  endfunction

  logic [31:0] mem [mhbf_pkg::MEM_WORDS];

  logic [3:0]  lc_r;
  logic [15:0] nb_r;
  logic [12:0] bw_r;
  logic [10:0] pc_r;
  logic [4:0]  dwc_r;

  mhbf_pkg::in_item_t  item_r;
  mhbf_pkg::out_item_t out_r;
  logic        out_strobe_r;
  logic [63:0] prod_r;
  logic [16:0] llen_r, lbase_r, qbase_r, srcblk_r, dstblk_r, end_r;
  logic [2:0]  lane_r, q_r;
  logic        half_r, rdv_r;
  logic [15:0] i_r;
  logic [3:0]  rlog_r;
  logic [AW-1:0] src_r, dst_r;
  logic [12:0] w_r;
  logic [10:0] r_r;
  logic [31:0] v_r, acc_r, rda_q, rdb_q;
  logic [3:0]  k_r;

  logic [16:0] nb2, i17, nb17, reach, mask2;
  logic [10:0] passes_m1;
  logic [4:0]  dw_eff;
  logic [31:0] mul_a, mul_b, vnew;
  logic        mul_en;
  logic [14:0] rev;
  logic [15:0] rp, rmask, rp_adj;
  logic [34:0] ld_sum;
  logic        ld_ok;
  logic [17:0] dg_pos;
  logic        dg_ok;
  logic        we, rea, reb;
  logic [AW-1:0] wa, ra, rb;
  logic [31:0] wd;
  logic [2:0]  lane_inc, q_inc;
  logic        q_wrap;

  assign nb2       = {nb_r, 1'b0};
  assign nb17      = {1'b0, nb_r};
  assign i17       = {1'b0, i_r};
  assign passes_m1 = (pc_r == 11'd0) ? 11'd0 : pc_r - 11'd1;
  assign dw_eff    = (dwc_r == 5'd0) ? 5'd1 :
                     (dwc_r > 5'(mhbf_pkg::MAX_DIGEST_WORDS)) ?
                     5'(mhbf_pkg::MAX_DIGEST_WORDS) : dwc_r;
  assign reach     = prod_r[48:32];
  assign lane_inc  = lane_r + 3'd1;
  assign q_inc     = q_r + 3'd1;
  assign q_wrap    = ({1'b0, q_r} == lc_r - 4'd1);

  assign rev    = rev15(i_r[14:0]);
  assign rp     = 16'(rev) >> (4'd15 - rlog_r);
  assign rmask  = 16'd1 << rlog_r;
  assign rp_adj = ((17'(rp) + 17'(rmask)) < i17) ? rp + rmask : rp;
  assign mask2  = 17'd2 << rlog_r;

  assign ld_sum = 35'(prod_r[33:0]) + 35'(item_r.seed_word_index);
  assign ld_ok  = ({1'b0, item_r.lane_index} < lc_r) &&
                  ({1'b0, item_r.seed_word_index} < bw_r) &&
                  (ld_sum < 35'(mhbf_pkg::MEM_WORDS));

  assign dg_pos = 18'(end_r) + 18'(k_r);
  assign dg_ok  = dg_pos >= 18'(dw_eff);
  assign vnew   = prod_r[31:0] + rdb_q;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd)
      mhbf_pkg::CMD_MUL_LLEN: begin mul_a = 32'(nb2); mul_b = 32'(bw_r); end
      mhbf_pkg::CMD_LD_MUL: begin mul_a = 32'(item_r.lane_index); mul_b = prod_r[31:0]; end
      mhbf_pkg::CMD_CK_MUL: begin mul_a = 32'(lc_r); mul_b = prod_r[31:0]; end
      mhbf_pkg::CMD_ADDR_SRC: begin mul_a = 32'(srcblk_r); mul_b = 32'(bw_r); end
      mhbf_pkg::CMD_ADDR_DST: begin mul_a = 32'(dstblk_r); mul_b = 32'(bw_r); end
      mhbf_pkg::CMD_CH_MUL: begin mul_a = v_r; mul_b = rda_q | 32'd3; end
      mhbf_pkg::CMD_SQ1: begin mul_a = v_r; mul_b = v_r; end
      mhbf_pkg::CMD_SQ2: begin mul_a = v_r; mul_b = prod_r[63:32]; end
      mhbf_pkg::CMD_SQ3: begin mul_a = 32'(i17 + nb17 - 17'd1); mul_b = prod_r[63:32]; end
      default: mul_en = 1'b0;
    endcase
  end

  // Memory port selection.
  always_comb begin
    we  = 1'b0;
    wa  = dst_r + AW'(w_r);
    wd  = vnew;
    rea = 1'b0;
    reb = 1'b0;
    ra  = dst_r - AW'(bw_r) + AW'(w_r);
    rb  = src_r + AW'(w_r);
    case (cmd)
      mhbf_pkg::CMD_CH_RD: begin rea = 1'b1; reb = 1'b1; end
      mhbf_pkg::CMD_CH_ADD: we = (r_r == passes_m1);
      mhbf_pkg::CMD_LD_WR: begin
        we = ld_ok;
        wa = ld_sum[AW-1:0];
        wd = item_r.seed_word;
      end
      mhbf_pkg::CMD_DG_RD: begin
        reb = dg_ok;
        rb  = AW'(dg_pos - 18'(dw_eff));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rea) rda_q <= mem[ra];
    if (reb) rdb_q <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r         <= 4'd1;
      nb_r         <= 16'd64;
      bw_r         <= 13'd64;
      pc_r         <= 11'd1;
      dwc_r        <= 5'd8;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          mhbf_pkg::REG_LANE_COUNT:      lc_r  <= cfg_data[3:0];
          mhbf_pkg::REG_BLOCKS_PER_HALF: nb_r  <= cfg_data;
          mhbf_pkg::REG_BLOCK_WORDS:     bw_r  <= cfg_data[12:0];
          mhbf_pkg::REG_PASS_COUNT:      pc_r  <= cfg_data[10:0];
          mhbf_pkg::REG_DIGEST_WORDS:    dwc_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd == mhbf_pkg::CMD_ERR_OUT || cmd == mhbf_pkg::CMD_DG_OUT) begin
        out_strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
    case (cmd)
      mhbf_pkg::CMD_ACCEPT: item_r <= in_data;
      mhbf_pkg::CMD_CK_MUL: llen_r <= prod_r[16:0];
      mhbf_pkg::CMD_ERR_OUT: out_r <= '{digest_word: 32'd0, digest_index: 4'd0,
                                        last_word: 1'b1, status: 1'b1};
      mhbf_pkg::CMD_RUN_INIT: begin
        half_r  <= 1'b0;
        lane_r  <= 3'd0;
        lbase_r <= 17'd0;
        v_r     <= 32'd1;
        rlog_r  <= 4'd0;
        i_r     <= 16'd1;
        q_r     <= 3'd0;
        qbase_r <= 17'd0;
      end
      mhbf_pkg::CMD_F_MASK: if (mask2 <= i17) rlog_r <= rlog_r + 4'd1;
      mhbf_pkg::CMD_F_SRC: begin
        srcblk_r <= lbase_r + 17'(rp_adj);
        dstblk_r <= lbase_r + i17;
      end
      mhbf_pkg::CMD_S_SRC: begin
        if (reach < i17) srcblk_r <= lbase_r + nb17 + i17 - 17'd1 - reach;
        else srcblk_r <= qbase_r + nb17 - 17'd1 - (reach - i17);
        dstblk_r <= lbase_r + nb17 + i17;
      end
      mhbf_pkg::CMD_ADDR_DST: src_r <= prod_r[AW-1:0];
      mhbf_pkg::CMD_ADDR_SET: begin
        dst_r <= prod_r[AW-1:0];
        w_r   <= 13'd0;
        r_r   <= 11'd0;
      end
      mhbf_pkg::CMD_CH_ADD: begin
        v_r <= vnew;
        if (w_r == bw_r - 13'd1) begin
          w_r <= 13'd0;
          r_r <= r_r + 11'd1;
        end else begin
          w_r <= w_r + 13'd1;
        end
      end
      mhbf_pkg::CMD_BLK_NEXT: begin
        i_r     <= i_r + 16'd1;
        q_r     <= q_wrap ? 3'd0 : q_inc;
        qbase_r <= q_wrap ? 17'd0 : qbase_r + nb2;
      end
      mhbf_pkg::CMD_LANE_NEXT: begin
        if ({1'b0, lane_r} != lc_r - 4'd1) begin
          lane_r  <= lane_inc;
          lbase_r <= lbase_r + nb2;
          v_r     <= 32'd1;
          rlog_r  <= 4'd0;
          i_r     <= half_r ? 16'd0 : 16'd1;
          q_r     <= lane_inc;
          qbase_r <= lbase_r + nb2;
        end else if (!half_r) begin
          half_r  <= 1'b1;
          lane_r  <= 3'd0;
          lbase_r <= 17'd0;
          v_r     <= 32'd1;
          i_r     <= 16'd0;
          q_r     <= 3'd0;
          qbase_r <= 17'd0;
        end else begin
          k_r    <= 4'd0;
          lane_r <= 3'd0;
          end_r  <= llen_r;
          acc_r  <= 32'd0;
        end
      end
      mhbf_pkg::CMD_DG_RD: rdv_r <= dg_ok;
      mhbf_pkg::CMD_DG_ACC: begin
        acc_r  <= acc_r ^ (rdv_r ? rdb_q : 32'd0);
        lane_r <= lane_inc;
        end_r  <= end_r + llen_r;
      end
      mhbf_pkg::CMD_DG_OUT: begin
        out_r  <= '{digest_word: acc_r, digest_index: k_r,
                    last_word: stat.k_last, status: 1'b0};
        k_r    <= k_r + 4'd1;
        lane_r <= 3'd0;
        end_r  <= llen_r;
        acc_r  <= 32'd0;
      end
      default: ;
    endcase
  end

  assign stat.is_run    = (item_r.opcode == mhbf_pkg::OP_RUN);
  assign stat.cfg_err   = (lc_r == 4'd0) || (lc_r > 4'(mhbf_pkg::MAX_LANES)) ||
                          (nb_r == 16'd0) || (bw_r == 13'd0) ||
                          (prod_r > 64'(mhbf_pkg::MEM_WORDS));
  assign stat.blk_end   = (i_r >= nb_r);
  assign stat.half      = half_r;
  assign stat.lane_last = ({1'b0, lane_r} == lc_r - 4'd1);
  assign stat.word_last = (w_r == bw_r - 13'd1);
  assign stat.pass_last = (r_r == passes_m1);
  assign stat.k_last    = ({1'b0, k_r} == dw_eff - 5'd1);

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

### tb/sv/tb_memory_hard_block_fill_top.sv
// ----------------------------------------------------------------------------
// tb_memory_hard_block_fill_top: self-checking bench for the block fill engine
// A directed table covers layout errors, ignored loads, digest saturation and
// the digest reaching below word 0. It is followed by random phases of seed
// loads and runs under many layouts, with every result checked against a
// behavioral copy of the engine.
// ----------------------------------------------------------------------------
module tb_memory_hard_block_fill_top;
  import mhbf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_strobe;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  memory_hard_block_fill_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Behavioral copy of the engine: memory, chain state and the registers.
  bit [31:0]   fill_mem [MEM_WORDS];
  bit [31:0]   chain_val;
  bit [3:0]    lanes_reg;
  bit [15:0]   bph_reg;
  bit [12:0]   bw_reg;
  bit [10:0]   passes_reg;
  bit [4:0]    digest_len_reg;

  out_item_t   digest_due [$];
  int          error_count = 0;
  int          accepted = 0;
  bit          late_part = 0;

  localparam out_item_t LAYOUT_ERR = '{digest_word: 32'd0, digest_index: 4'd0,
                                       last_word: 1'b1, status: 1'b1};

  function automatic bit [31:0] mem_read(longint unsigned a);
    return (a >= MEM_WORDS) ? 32'd0 : fill_mem[a];
  endfunction

  function automatic bit layout_bad();
    longint unsigned need;
    need = 2 * longint'(lanes_reg) * bph_reg * bw_reg;
    return lanes_reg == 0 || lanes_reg > MAX_LANES || bph_reg == 0 || bw_reg == 0 ||
           need > MEM_WORDS;
  endfunction

  // One block: all passes except the last only advance the chain value.
  task automatic chain_block(longint unsigned src, longint unsigned dst);
    longint unsigned prev;
    bit [31:0] v;
    int passes;
    prev = dst - bw_reg;
    v = chain_val;
    passes = (passes_reg == 0) ? 1 : passes_reg;
    for (int r = 0; r < passes; r++)
      for (int w = 0; w < bw_reg; w++) begin
        v = v * (mem_read(prev + w) | 32'd3) + mem_read(src + w);
        if (r == passes - 1 && dst + w < MEM_WORDS) fill_mem[dst + w] = v;
      end
    chain_val = v;
  endtask

  function automatic int unsigned bit_reverse(int unsigned x, int unsigned mask);
    int unsigned res;
    res = 0;
    while (mask > 1) begin
      res = (res << 1) | (x & 1);
      x = x >> 1;
      mask = mask >> 1;
    end
    return res;
  endfunction

  // Works out the effect of one accepted transaction and queues its results.
  task automatic fill_predict(in_item_t it);
    longint unsigned lane_len, base, src, v, v2, v3, end_addr;
    int unsigned lanes, rmask, rp, reach, dw, q, b;
    bit [31:0] acc;
    out_item_t res;
    lanes = (lanes_reg > MAX_LANES) ? MAX_LANES : lanes_reg;
    lane_len = 2 * longint'(bph_reg) * bw_reg;
    if (it.opcode == OP_LOAD) begin
      if (it.lane_index < lanes && it.seed_word_index < bw_reg &&
          it.lane_index * lane_len + it.seed_word_index < MEM_WORDS)
        fill_mem[it.lane_index * lane_len + it.seed_word_index] = it.seed_word;
      return;
    end
    if (layout_bad()) begin
      digest_due.push_back(LAYOUT_ERR);
      return;
    end
    for (int p = 0; p < lanes_reg; p++) begin
      base = 2 * longint'(p) * bph_reg * bw_reg;
      chain_val = 32'd1;
      rmask = 1;
      for (int unsigned i = 1; i < bph_reg; i++) begin
        if ((rmask << 1) <= i) rmask = rmask << 1;
        rp = bit_reverse(i, rmask);
        if (rp + rmask < i) rp = rp + rmask;
        chain_block(base + longint'(bw_reg) * rp, base + longint'(bw_reg) * i);
      end
    end
    for (int p = 0; p < lanes_reg; p++) begin
      base = (2 * longint'(p) + 1) * bph_reg * bw_reg;
      chain_val = 32'd1;
      for (int unsigned i = 0; i < bph_reg; i++) begin
        v = chain_val;
        v2 = (v * v) >> 32;
        v3 = (v * v2) >> 32;
        reach = 32'(((longint'(i) + bph_reg - 1) * v3) >> 32);
        if (reach < i)
          src = base + longint'(i - 1 - reach) * bw_reg;
        else begin
          q = (p + i) % lanes_reg;
          b = bph_reg - 1 - (reach - i);
          src = (2 * longint'(bph_reg) * q + b) * bw_reg;
        end
        chain_block(src, base + longint'(bw_reg) * i);
      end
    end
    dw = (digest_len_reg == 0) ? 1 : digest_len_reg;
    if (dw > MAX_DIGEST_WORDS) dw = MAX_DIGEST_WORDS;
    for (int unsigned k = 0; k < dw; k++) begin
      acc = '0;
      for (int p = 0; p < lanes_reg; p++) begin
        end_addr = (longint'(p) + 1) * lane_len;
        // Words before the start of memory count as zero.
        if (end_addr + k >= dw) acc ^= mem_read(end_addr + k - dw);
      end
      res.digest_word = acc;
      res.digest_index = k[3:0];
      res.last_word = (k + 1 == dw);
      res.status = 1'b0;
      digest_due.push_back(res);
    end
  endtask

  // Result checker: the engine cannot be stalled, so every strobe is a
  // completed transaction and is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (digest_due.size() == 0) begin
        $error("unexpected result %h", out_data);
        error_count++;
      end else begin
        out_item_t want;
        want = digest_due.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, out_data.digest_word);
          error_count++;
        end
        if (out_data.digest_index !== want.digest_index) begin
          $error("digest_index: expected %0d, got %0d", want.digest_index,
                 out_data.digest_index);
          error_count++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word: expected %b, got %b", want.last_word, out_data.last_word);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // Presents one transaction and waits until the engine takes it. The caller
  // is at a rising edge; start stays high so back-to-back items need no gap.
  task automatic issue(in_item_t it, bit typed, out_item_t typed_res);
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed) digest_due.push_back(typed_res);
    else fill_predict(it);
    accepted++;
    // Sender-side idling in random bursts, none in the last part of the run.
    if (!late_part && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Waits until every expected result is in and the engine is idle, plus a
  // margin for a load that may still be writing.
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (busy || digest_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Register write; the caller lowers cfg_we after the last write of a group.
  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_LANE_COUNT:      lanes_reg = val[3:0];
      REG_BLOCKS_PER_HALF: bph_reg = val;
      REG_BLOCK_WORDS:     bw_reg = val[12:0];
      REG_PASS_COUNT:      passes_reg = val[10:0];
      REG_DIGEST_WORDS:    digest_len_reg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_layout(int l, int nb, int bw, int ps, int dw);
    quiesce();
    reg_write(REG_LANE_COUNT, 16'(l));
    reg_write(REG_BLOCKS_PER_HALF, 16'(nb));
    reg_write(REG_BLOCK_WORDS, 16'(bw));
    reg_write(REG_PASS_COUNT, 16'(ps));
    reg_write(REG_DIGEST_WORDS, 16'(dw));
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t load_item(int lane, int widx, bit [31:0] word);
    in_item_t it;
    it.opcode = OP_LOAD;
    it.lane_index = 3'(lane);
    it.seed_word_index = 12'(widx);
    it.seed_word = word;
    return it;
  endfunction

  function automatic in_item_t run_item();
    in_item_t it;
    it = load_item($urandom_range(0, 7), $urandom_range(0, 4095), $urandom);
    it.opcode = OP_RUN;
    return it;
  endfunction

  // Directed table: a row is a register write or a transaction. Rows with
  // a typed result carry it; the others are predicted.
  typedef struct {
    bit        is_reg;
    logic [2:0] idx;
    logic [15:0] val;
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t reg_row(logic [2:0] idx, logic [15:0] val);
    plan_row_t r;
    r = '{is_reg: 1'b1, idx: idx, val: val, item: '0, typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic plan_row_t item_row(in_item_t it, bit typed);
    plan_row_t r;
    r = '{is_reg: 1'b0, idx: '0, val: '0, item: it, typed: typed, res: LAYOUT_ERR};
    return r;
  endfunction

  initial begin
    int l, nb, bw, ps, dw, n_runs;
    bit [31:0] pats [8];

    lanes_reg = 4'd1; bph_reg = 16'd64; bw_reg = 13'd64; passes_reg = 11'd1;
    digest_len_reg = 5'd8;
    pats = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE,
             32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0003, 32'hFFFF_FFFC};

    // Layout errors: zero lanes, too many lanes, memory overflow, zero sizes.
    plan.push_back(reg_row(REG_LANE_COUNT, 16'd0));
    plan.push_back(item_row(run_item(), 1'b1));
    plan.push_back(reg_row(REG_LANE_COUNT, 16'd9));
    plan.push_back(item_row(run_item(), 1'b1));
    plan.push_back(reg_row(REG_LANE_COUNT, 16'd8));
    plan.push_back(reg_row(REG_BLOCKS_PER_HALF, 16'd32768));
    plan.push_back(item_row(run_item(), 1'b1));
    plan.push_back(reg_row(REG_LANE_COUNT, 16'd1));
    plan.push_back(reg_row(REG_BLOCKS_PER_HALF, 16'd16));
    plan.push_back(reg_row(REG_BLOCK_WORDS, 16'd4096));
    plan.push_back(item_row(run_item(), 1'b1));
    plan.push_back(reg_row(REG_BLOCK_WORDS, 16'd0));
    plan.push_back(item_row(run_item(), 1'b1));
    plan.push_back(reg_row(REG_BLOCKS_PER_HALF, 16'd0));
    plan.push_back(reg_row(REG_BLOCK_WORDS, 16'd1));
    plan.push_back(item_row(run_item(), 1'b1));
    // Smallest layout, zero passes, zero digest length, ignored loads.
    plan.push_back(reg_row(REG_BLOCKS_PER_HALF, 16'd1));
    plan.push_back(reg_row(REG_PASS_COUNT, 16'd0));
    plan.push_back(reg_row(REG_DIGEST_WORDS, 16'd0));
    plan.push_back(item_row(load_item(7, 0, 32'h1234_5678), 1'b0));
    plan.push_back(item_row(load_item(0, 4095, 32'h1234_5678), 1'b0));
    plan.push_back(item_row(load_item(0, 0, 32'hFFFF_FFFF), 1'b0));
    plan.push_back(item_row(run_item(), 1'b0));
    // All lanes, digest length saturating and reaching below word 0.
    plan.push_back(reg_row(REG_LANE_COUNT, 16'd8));
    plan.push_back(reg_row(REG_DIGEST_WORDS, 16'd31));
    for (int p = 0; p < 8; p++) plan.push_back(item_row(load_item(p, 0, pats[p]), 1'b0));
    plan.push_back(item_row(run_item(), 1'b0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i - 1].is_reg) quiesce();
        reg_write(plan[i].idx, plan[i].val);
        if (i + 1 == plan.size() || !plan[i + 1].is_reg) cfg_we <= 1'b0;
      end else
        issue(plan[i].item, plan[i].typed, plan[i].res);
    end

    // Random phases: a layout, a full set of seeds, then runs with reloads
    // and ignored loads mixed in.
    for (int ph = 0; accepted < 270; ph++) begin
      late_part = accepted > 220;
      l = $urandom_range(1, 8);
      nb = $urandom_range(1, 6);
      bw = $urandom_range(1, 8);
      ps = $urandom_range(0, 3);
      dw = $urandom_range(0, 31);
      if (ph == 3) begin
        // Whole memory in one lane.
        l = 1; nb = 256; bw = 128; ps = 1; dw = 16;
      end else if (ph % 5 == 1) begin
        // Long pass chains on a tiny layout.
        l = $urandom_range(1, 2); nb = $urandom_range(1, 2); bw = 1;
        ps = $urandom_range(1024, 2047);
      end else if (ph % 4 == 2) begin
        l = $urandom_range(0, 15);
        nb = $urandom_range(0, 65535);
        bw = $urandom_range(0, 8191);
        if (l >= 1 && l <= 8 && 2 * l * nb * bw <= MEM_WORDS && nb != 0 && bw != 0)
          nb = 65535;
      end
      set_layout(l, nb, bw, ps, dw);
      if (!layout_bad())
        for (int p = 0; p < lanes_reg; p++)
          for (int w = 0; w < bw_reg; w++) begin
            if ($urandom_range(0, 5) == 0)
              issue(load_item($urandom_range(0, 7), $urandom_range(0, 4095), $urandom),
                    1'b0, '0);
            issue(load_item(p, w, $urandom), 1'b0, '0);
          end
      n_runs = $urandom_range(1, 3);
      for (int r = 0; r < n_runs; r++) begin
        if (!layout_bad() && r > 0)
          repeat ($urandom_range(0, 4))
            issue(load_item($urandom_range(0, lanes_reg - 1),
                            $urandom_range(0, bw_reg - 1), $urandom), 1'b0, '0);
        issue(run_item(), 1'b0, '0);
      end
    end

    quiesce();
    repeat (50) @(posedge clk);
    if (error_count == 0 && digest_due.size() == 0)
      $display("tb_memory_hard_block_fill_top: clean");
    else
      $display("tb_memory_hard_block_fill_top: errors");
    $finish;
  end

  // Hard limit on the whole run.
  initial begin
    #80000000;
    $display("tb_memory_hard_block_fill_top: errors");
    $finish;
  end

endmodule

### sim.f
design/mhbf_pkg.sv
design/mhbf_ctrl.sv
design/mhbf_dpath.sv
design/memory_hard_block_fill_top.sv
tb/sv/tb_memory_hard_block_fill_top.sv
